>>> sv/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants of the timestamp to calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

  // Division by a constant multiplies by a rounded-up reciprocal of its odd
  // factor after the power-of-two factor has been shifted off.
  // 86400 = 128 * 675: the day count is bits 50:35 of the product.
  localparam logic [25:0] DayRecip  = 26'd50903317;
  // 3600 = 16 * 225: the hour is bits 25:21 of the product.
  localparam logic [13:0] HourRecip = 14'd9321;
  // 60 = 4 * 15: the minute is bits 19:14 of the product.
  localparam logic [10:0] MinRecip  = 11'd1093;

  localparam logic [32:0] DaySecs  = 33'd86400;
  localparam logic [16:0] HourSecs = 17'd3600;
  localparam logic [11:0] MinSecs  = 12'd60;

  localparam logic [11:0] BaseYear      = 12'd1970;
  localparam logic [6:0]  BaseYearMod100 = 7'd70;
  localparam logic [8:0]  BaseYearMod400 = 9'd370;
  // 1970-01-01 was a Thursday; weekday index 0 is Sunday.
  localparam logic [2:0]  BaseWeekday   = 3'd4;
  localparam logic [3:0]  LastMonth     = 4'd11;
  localparam logic [3:0]  February      = 4'd1;

  typedef struct packed {
    logic load;
    logic save_days;
    logic save_tod;
    logic year_step;
    logic month_step;
    logic save_hour;
    logic save_hrem;
    logic save_min;
    logic finish;
  } tcd_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } tcd_sts_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    begin
      unique case (m)
        4'd1:                      d = leap ? 5'd29 : 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
        default:                   d = 5'd31;
      endcase
      return d;
    end
  endfunction

  // Weekday index plus a small step, wrapped to 0..6.
  function automatic logic [2:0] wd_add(input logic [2:0] w, input logic [1:0] a);
    logic [3:0] s;
    begin
      s = {1'b0, w} + {2'b00, a};
      if (s >= 4'd7) begin
        s = s - 4'd7;
      end
      return s[2:0];
    end
  endfunction

  // Remainder by seven of a value up to 36.
  function automatic logic [2:0] mod7_small(input logic [5:0] v);
    logic [5:0] r;
    begin
      r = v;
      for (int i = 0; i < 5; i++) begin
        if (r >= 6'd7) begin
          r = r - 6'd7;
        end
      end
      return r[2:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/tcd_dpath.sv
// ----------------------------------------------------------------------------
// tcd_dpath
// Reciprocal dividers, year and month walkers, and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_dpath import tcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] epoch_seconds_i,
  input  wire tcd_cmd_t    cmd_i,
  output tcd_sts_t         sts_o,
  output logic             done_o,
  output logic [5:0]       second_o,
  output logic [5:0]       minute_o,
  output logic [4:0]       hour_o,
  output logic [2:0]       weekday_o,
  output logic [4:0]       day_of_month_o,
  output logic [3:0]       month_o,
  output logic [11:0]      year_o
);

  logic [31:0] rem_q, rem_d;
  logic [15:0] days_q, days_d;
  logic [11:0] year_q, year_d;
  logic [6:0]  y100_q, y100_d;
  logic [8:0]  y400_q, y400_d;
  logic [2:0]  wd_q, wd_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  hr_q, hr_d;
  logic [5:0]  mn_q, mn_d;
  logic        done_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q, dom_q;
  logic [2:0]  wday_q;
  logic [3:0]  month_q;
  logic [11:0] yout_q;

  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [50:0] day_prod;
  logic [32:0] day_secs;
  logic [25:0] hr_prod;
  logic [16:0] hr_secs;
  logic [19:0] mn_prod;
  logic [11:0] mn_secs;
  logic [11:0] sec_val;

  // The register holds the seconds word, then the time of day, then the
  // seconds left within the hour.
  assign day_prod = {26'd0, rem_q[31:7]} * {25'd0, DayRecip};
  assign day_secs = {17'd0, days_q} * DaySecs;
  assign hr_prod  = {13'd0, rem_q[16:4]} * {12'd0, HourRecip};
  assign hr_secs  = {12'd0, hr_q} * HourSecs;
  assign mn_prod  = {10'd0, rem_q[11:2]} * {9'd0, MinRecip};
  assign mn_secs  = {6'd0, mn_q} * MinSecs;
  assign sec_val  = rem_q[11:0] - mn_secs;

  assign leap = (year_q[1:0] == 2'b00) && ((y100_q != 7'd0) || (y400_q == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_days(mon_q, leap);

  assign sts_o.year_done  = days_q < 16'(ylen);
  assign sts_o.month_done = (mon_q == LastMonth) || (days_q < 16'(mlen));

  always_comb begin
    rem_d  = rem_q;
    days_d = days_q;
    year_d = year_q;
    y100_d = y100_q;
    y400_d = y400_q;
    wd_d   = wd_q;
    mon_d  = mon_q;
    hr_d   = hr_q;
    mn_d   = mn_q;

    if (cmd_i.load) begin
      rem_d  = epoch_seconds_i;
      year_d = BaseYear;
      y100_d = BaseYearMod100;
      y400_d = BaseYearMod400;
      wd_d   = BaseWeekday;
      mon_d  = '0;
    end else begin
      if (cmd_i.save_days) begin
        days_d = day_prod[50:35];
      end
      if (cmd_i.save_tod) begin
        rem_d = rem_q - day_secs[31:0];
      end
      if (cmd_i.year_step && !sts_o.year_done) begin
        days_d = days_q - 16'(ylen);
        year_d = year_q + 12'd1;
        y100_d = (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
        y400_d = (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
        wd_d   = wd_add(wd_q, leap ? 2'd2 : 2'd1);
      end
      if (cmd_i.month_step && !sts_o.month_done) begin
        days_d = days_q - 16'(mlen);
        mon_d  = mon_q + 4'd1;
        // Month lengths 28 to 31 advance the weekday by their two low bits.
        wd_d   = wd_add(wd_q, mlen[1:0]);
      end
      if (cmd_i.save_hour) begin
        hr_d = hr_prod[25:21];
      end
      if (cmd_i.save_hrem) begin
        rem_d = rem_q - {15'd0, hr_secs};
      end
      if (cmd_i.save_min) begin
        mn_d = mn_prod[19:14];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    days_q <= days_d;
    year_q <= year_d;
    y100_q <= y100_d;
    y400_q <= y400_d;
    wd_q   <= wd_d;
    mon_q  <= mon_d;
    hr_q   <= hr_d;
    mn_q   <= mn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  // Result word is held until the next conversion finishes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sec_q   <= sec_val[5:0];
      min_q   <= mn_q;
      hour_q  <= hr_q;
      wday_q  <= mod7_small(6'(wd_q) + {1'b0, days_q[4:0]}) + 3'd1;
      dom_q   <= days_q[4:0] + 5'd1;
      month_q <= mon_q + 4'd1;
      yout_q  <= year_q;
    end
  end

  assign done_o         = done_q;
  assign second_o       = sec_q;
  assign minute_o       = min_q;
  assign hour_o         = hour_q;
  assign weekday_o      = wday_q;
  assign day_of_month_o = dom_q;
  assign month_o        = month_q;
  assign year_o         = yout_q;

endmodule

`default_nettype wire

>>> sv/tcd_ctrl.sv
// ----------------------------------------------------------------------------
// tcd_ctrl
// Sequencer: day split, year walk, month walk, hour, minute and second split.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_ctrl import tcd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire tcd_sts_t sts_i,
  output tcd_cmd_t      cmd_o,
  output logic          busy_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DAYS  = 9'b000000010,
    S_TOD   = 9'b000000100,
    S_YEAR  = 9'b000001000,
    S_MONTH = 9'b000010000,
    S_HOUR  = 9'b000100000,
    S_HREM  = 9'b001000000,
    S_MIN   = 9'b010000000,
    S_SEC   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DAYS;
        end
      end
      S_DAYS: begin
        cmd_o.save_days = 1'b1;
        state_d         = S_TOD;
      end
      S_TOD: begin
        cmd_o.save_tod = 1'b1;
        state_d        = S_YEAR;
      end
      S_YEAR: begin
        cmd_o.year_step = 1'b1;
        if (sts_i.year_done) begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (sts_i.month_done) begin
          state_d = S_HOUR;
        end
      end
      S_HOUR: begin
        cmd_o.save_hour = 1'b1;
        state_d         = S_HREM;
      end
      S_HREM: begin
        cmd_o.save_hrem = 1'b1;
        state_d         = S_MIN;
      end
      S_MIN: begin
        cmd_o.save_min = 1'b1;
        state_d        = S_SEC;
      end
      S_SEC: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

  a_start_enters_days: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> state_q == S_DAYS)
    else $error("accepted word did not start the day split");

  a_finish_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after finishing");

  a_year_walk_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_YEAR && !sts_i.year_done) |=> state_q == S_YEAR)
    else $error("year walk left before the remaining days fit in one year");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

endmodule

`default_nettype wire

>>> sv/timestamp_to_calendar_date.sv
// ----------------------------------------------------------------------------
// timestamp_to_calendar_date
// Converts seconds since 1970-01-01 UTC into Gregorian date and time of day.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high while busy_o is low; busy_o then stays
// high until the conversion is complete. The result appears on the output
// ports together with a one-cycle done_o strobe, and it is not held off by
// the receiver, so capture it on that cycle (the ports keep their value until
// the next result, but only the strobe marks it). A conversion first splits
// the day count from the time of day, then walks the years from 1970 and the
// months one step at a time, then splits hour, minute and second; the year
// walk takes most of the time from acceptance to the strobe. busy_o drops on
// the strobe cycle, so the next word may be accepted there.
`default_nettype none

module timestamp_to_calendar_date import tcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] epoch_seconds_i,
  output logic             done_o,
  output logic [5:0]       second_o,
  output logic [5:0]       minute_o,
  output logic [4:0]       hour_o,
  output logic [2:0]       weekday_o,
  output logic [4:0]       day_of_month_o,
  output logic [3:0]       month_o,
  output logic [11:0]      year_o
);

  tcd_cmd_t cmd;
  tcd_sts_t sts;

  tcd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  tcd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .epoch_seconds_i (epoch_seconds_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .second_o        (second_o),
    .minute_o        (minute_o),
    .hour_o          (hour_o),
    .weekday_o       (weekday_o),
    .day_of_month_o  (day_of_month_o),
    .month_o         (month_o),
    .year_o          (year_o)
  );

endmodule

`default_nettype wire
